/* src/itda_pkg.sv */
package itda_pkg;

    // Field widths of the stream payloads.
    localparam int DataW      = 64;
    localparam int SelW       = 2;
    localparam int CapW       = 8;
    localparam int CharW      = 8;
    localparam int LenW       = 5;
    localparam int MaxWidthDef = 64;

    // Character codes.
    localparam logic [CharW-1:0] AsciiZero  = 8'h30;
    localparam logic [CharW-1:0] AsciiMinus = 8'h2D;
    localparam logic [CharW-1:0] AsciiNone  = 8'h00;

    // Operand width selector codes.
    localparam logic [SelW-1:0] SelW8  = 2'd0;
    localparam logic [SelW-1:0] SelW16 = 2'd1;
    localparam logic [SelW-1:0] SelW32 = 2'd2;
    localparam logic [SelW-1:0] SelW64 = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic count;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iter_last;
        logic emit_last;
    } t_dp_status;

endpackage

/* src/itda_datapath.sv */
module itda_datapath
    import itda_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDef
) (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [DataW-1:0]   i_raw,
    input  logic [SelW-1:0]    i_sel,
    input  logic               i_signed,
    input  logic [CapW-1:0]    i_cap,
    output t_dp_status         o_status,
    output logic [CharW-1:0]   o_char,
    output logic               o_fits,
    output logic               o_last,
    output logic [LenW-1:0]    o_len
);

    // Decimal digits of the largest MAX_WIDTH-bit value: floor(W*log10(2)) + 1.
    localparam int Digits  = (MAX_WIDTH * 30103) / 100000 + 1;
    localparam int DigIdxW = (Digits > 1) ? $clog2(Digits) : 1;
    localparam int NdW     = $clog2(Digits + 1);
    localparam int IterW   = $clog2(MAX_WIDTH + 1);
    localparam int W0      = (8  < MAX_WIDTH) ? 8  : MAX_WIDTH;
    localparam int W1      = (16 < MAX_WIDTH) ? 16 : MAX_WIDTH;
    localparam int W2      = (32 < MAX_WIDTH) ? 32 : MAX_WIDTH;
    localparam int W3      = (64 < MAX_WIDTH) ? 64 : MAX_WIDTH;

    logic [MAX_WIDTH-1:0] r_bin;
    logic [3:0]           r_bcd [Digits];
    logic [IterW-1:0]     r_iter;
    logic                 r_neg;
    logic [CapW-1:0]      r_cap;
    logic                 r_fits;
    logic                 r_sign_pend;
    logic [DigIdxW-1:0]   r_dig_idx;
    logic [LenW-1:0]      r_total;
    logic [CharW-1:0]     r_char;
    logic                 r_out_fits;
    logic                 r_out_last;
    logic [LenW-1:0]      r_out_len;

    // Operand preparation for a new item.
    logic [IterW-1:0]     w_len;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] val;
    logic                 neg;
    logic [MAX_WIDTH-1:0] mag;
    logic [MAX_WIDTH-1:0] aligned;

    always_comb begin
        unique case (i_sel)
            SelW8:   w_len = IterW'(W0);
            SelW16:  w_len = IterW'(W1);
            SelW32:  w_len = IterW'(W2);
            SelW64:  w_len = IterW'(W3);
            default: w_len = IterW'(W3);
        endcase
        mask    = {MAX_WIDTH{1'b1}} >> (IterW'(MAX_WIDTH) - w_len);
        val     = i_raw[MAX_WIDTH-1:0] & mask;
        neg     = i_signed && (|(val & mask & ~(mask >> 1)));
        mag     = neg ? ((~val + 1'b1) & mask) : val;
        // The top bit of the operand sits at the top of the shift register.
        aligned = mag << (IterW'(MAX_WIDTH) - w_len);
    end

    // One shift-add-3 step.
    logic [3:0] adj [Digits];

    always_comb begin
        for (int i = 0; i < Digits; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    // Digit count: position of the highest nonzero digit, at least one.
    logic [NdW-1:0] nd;

    always_comb begin
        nd = NdW'(1);
        for (int i = 1; i < Digits; i++) begin
            if (r_bcd[i] != 4'd0) begin
                nd = NdW'(i + 1);
            end
        end
    end

    // Character of the current beat.
    logic [CharW-1:0] cur_char;
    logic             cur_last;
    logic [LenW-1:0]  cur_len;

    always_comb begin
        if (!r_fits) begin
            cur_char = AsciiNone;
            cur_last = 1'b1;
            cur_len  = '0;
        end else if (r_sign_pend) begin
            cur_char = AsciiMinus;
            cur_last = 1'b0;
            cur_len  = '0;
        end else begin
            cur_char = AsciiZero + {4'b0000, r_bcd[r_dig_idx]};
            cur_last = (r_dig_idx == '0);
            cur_len  = cur_last ? r_total : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= aligned;
            r_iter <= w_len;
            r_neg  <= neg;
            r_cap  <= i_cap;
            for (int i = 0; i < Digits; i++) begin
                r_bcd[i] <= 4'd0;
            end
        end else if (i_cmd.step) begin
            r_bin    <= r_bin << 1;
            r_iter   <= r_iter - 1'b1;
            r_bcd[0] <= {adj[0][2:0], r_bin[MAX_WIDTH-1]};
            for (int i = 1; i < Digits; i++) begin
                r_bcd[i] <= {adj[i][2:0], adj[i-1][3]};
            end
        end

        if (i_cmd.count) begin
            r_fits      <= (CapW'(nd) <= r_cap);
            r_sign_pend <= r_neg;
            r_dig_idx   <= DigIdxW'(nd - 1'b1);
            r_total     <= LenW'(nd) + LenW'(r_neg);
        end else if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (r_dig_idx != '0) begin
                r_dig_idx <= r_dig_idx - 1'b1;
            end
        end

        if (i_cmd.emit) begin
            r_char     <= cur_char;
            r_out_fits <= r_fits;
            r_out_last <= cur_last;
            r_out_len  <= cur_len;
        end
    end

    assign o_status.iter_last = (r_iter == IterW'(1));
    assign o_status.emit_last = cur_last;
    assign o_char = r_char;
    assign o_fits = r_out_fits;
    assign o_last = r_out_last;
    assign o_len  = r_out_len;

endmodule

/* src/itda_ctrl.sv */
module itda_ctrl
    import itda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_COUNT,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step  = (r_state == S_CONVERT);
        o_cmd.count = (r_state == S_COUNT);
        o_cmd.emit  = (r_state == S_EMIT) && slot_free;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CONVERT;
                    end
                end
                S_CONVERT: begin
                    if (i_status.iter_last) begin
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free && i_status.emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_convert_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONVERT && !i_status.iter_last) |=> (r_state == S_CONVERT))
        else $error("conversion left before the last step");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.emit))
        else $error("output valid rose without an emitted character");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.emit_last) |=> (r_state == S_IDLE && r_out_valid))
        else $error("last character did not return the controller to idle");

endmodule

/* src/integer_to_decimal_ascii_unit.sv */
// A value of w bits (8, 16, 32 or 64) is loaded at the accepting edge and converted by
// shift-add-3 steps; then its digits are counted and its characters handed out as m_axis_tready allows.
// A new item is taken only after the last character of the previous one has entered the
// one-character output register, since the single shared double-dabble register serves every item.
// Reset is synchronous and active low; it returns the controller to idle and drops m_axis_tvalid.
// No memory needs clearing, so an item can be taken as soon as reset is released.
module integer_to_decimal_ascii_unit
    import itda_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] raw_value, [71:64] capacity
    input  logic [2:0]  s_axis_tuser,   // [1:0] operand_width, [2] is_signed

    // Output stream, one character per beat.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] ascii_char, [12:8] total_length, [15:13] zero
    output logic [0:0]  m_axis_tuser,   // [0] fits
    output logic        m_axis_tlast    // last_char
);

    // The controller sequences one item at a time: it takes a beat only when idle,
    // runs the conversion, counts digits, then hands out characters one per beat.
    // The output register lets the next item be taken while the last character
    // of the previous one still waits on the master side.
    t_dp_cmd    cmd;
    t_dp_status status;

    logic [CharW-1:0] out_char;
    logic             out_fits;
    logic             out_last;
    logic [LenW-1:0]  out_len;

    itda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // The datapath holds the binary shift register and the BCD digit row. Each step
    // adds three to every digit of five or more and shifts the whole row left by one,
    // pulling in the next magnitude bit. Negative values are converted from their
    // magnitude, so the most negative value of each width comes out right.
    itda_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_raw    (s_axis_tdata[DataW-1:0]),
        .i_sel    (s_axis_tuser[SelW-1:0]),
        .i_signed (s_axis_tuser[SelW]),
        .i_cap    (s_axis_tdata[DataW+CapW-1:DataW]),
        .o_status (status),
        .o_char   (out_char),
        .o_fits   (out_fits),
        .o_last   (out_last),
        .o_len    (out_len)
    );

    // A refused item shows as a single beat with a zero character, fits low,
    // tlast high and a zero length.
    assign m_axis_tdata = {3'b000, out_len, out_char};
    assign m_axis_tuser = out_fits;
    assign m_axis_tlast = out_last;

endmodule

/* sim/testbench.sv */
module testbench
    import itda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Testbench for the integer to decimal ASCII converter.
    //
    // The input stream carries one integer per beat, with its width selector,
    // signedness flag and buffer capacity. The output stream returns one character
    // per beat. A refused conversion returns a single beat with fits cleared.
    // Every accepted input beat is turned into a list of expected output beats.
    // Each accepted output beat is then compared, field by field, with the oldest
    // beat still waiting in that list.

    // Width cap that the converter applies to the selector.
    localparam int WidthCap = MaxWidthDef;
    // Cycles without any accepted beat before the run is declared hung. The
    // slowest correct gap is a 64-bit conversion, plus
    // random stalls on both sides. That is far below this figure.
    localparam int unsigned HangLimit = 2000;
    // Settling time after the last expected beat. It covers one whole
    // conversion, so a stray trailing beat would still be seen.
    localparam int unsigned DrainCycles = 100;
    localparam int unsigned RandomPerPhase = 66;

    typedef enum logic [1:0] {
        ROW_PREDICT,   // expected beats come from the predictor
        ROW_TEXT,      // expected characters are typed into the row
        ROW_REFUSED    // a single refusal beat is expected
    } t_row_kind;

    typedef struct {
        logic [63:0] raw;
        logic [1:0]  sel;
        logic        sgn;
        logic [7:0]  cap;
        t_row_kind   kind;
        string       text;
    } t_stim_row;

    // One output beat as the converter should present it.
    typedef struct {
        logic [CharW-1:0] ch;
        logic             fits;
        logic             last;
        logic [LenW-1:0]  length;
    } t_char_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;    // [63:0] raw_value, [71:64] capacity
    logic [2:0]  s_axis_tuser = '0;    // [1:0] operand_width, [2] is_signed
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] ascii_char, [12:8] total_length, [15:13] zero
    logic [0:0]  m_axis_tuser;         // [0] fits
    logic        m_axis_tlast;         // last_char

    t_char_beat  expected_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned beats_out = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    integer_to_decimal_ascii_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] output beat %0d: %s expected %0d, got %0d",
                 $realtime, beats_out, field, want, got);
        mismatch_count++;
    endtask

    // Marks the most recently queued beat as the end of a conversion.
    function automatic void close_conversion(input int unsigned total);
        expected_chars[expected_chars.size() - 1].last   = 1'b1;
        expected_chars[expected_chars.size() - 1].length = LenW'(total);
    endfunction

    function automatic void queue_refusal();
        t_char_beat b;
        b = '{ch: AsciiNone, fits: 1'b0, last: 1'b1, length: '0};
        expected_chars.push_back(b);
    endfunction

    function automatic void queue_text(input string s);
        t_char_beat b;
        for (int i = 0; i < s.len(); i++) begin
            b = '{ch: CharW'(s[i]), fits: 1'b1, last: 1'b0, length: '0};
            expected_chars.push_back(b);
        end
        close_conversion(s.len());
    endfunction

    // Converts the integer the way the block should. The digits are taken from
    // the magnitude, so the most negative value of every width is covered.
    // The resulting beats are appended to expected_chars.
    function automatic void predict_decimal(input logic [63:0] raw, input logic [1:0] sel,
                                            input logic sgn, input logic [7:0] cap);
        int unsigned bits;
        int unsigned ndig;
        logic [63:0] mask;
        logic [63:0] val;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digits [20];
        t_char_beat  b;
        bits = 8 << sel;
        if (bits > WidthCap) bits = WidthCap;
        mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
        val  = raw & mask;
        neg  = sgn && val[bits-1];
        mag  = neg ? ((~val + 64'd1) & mask) : val;
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            ndig++;
        end while (mag != 0);
        // The sign is not counted against the capacity.
        if (ndig > cap) begin
            queue_refusal();
        end else begin
            if (neg) begin
                b = '{ch: AsciiMinus, fits: 1'b1, last: 1'b0, length: '0};
                expected_chars.push_back(b);
            end
            for (int k = ndig - 1; k >= 0; k--) begin
                b = '{ch: AsciiZero + CharW'(digits[k]), fits: 1'b1, last: 1'b0, length: '0};
                expected_chars.push_back(b);
            end
            close_conversion(ndig + (neg ? 1 : 0));
        end
    endfunction

    // Offers one input beat and returns at the edge where it is accepted.
    // tvalid is left high on return. A following call either keeps it high
    // with new data or lowers it for an idle cycle. Because of this, valid
    // never gets two assignments in the same time step.
    task automatic offer_integer(input logic [63:0] raw, input logic [1:0] sel,
                                 input logic sgn, input logic [7:0] cap);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cap, raw};
        s_axis_tuser  <= {sgn, sel};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker: every accepted character beat must match the oldest
    // beat still expected.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("beat with nothing expected, data", 64'd0,
                                64'(m_axis_tdata));
            end else begin
                if (m_axis_tdata[7:0] !== expected_chars[0].ch)
                    report_mismatch("ascii_char", 64'(expected_chars[0].ch),
                                    64'(m_axis_tdata[7:0]));
                if (m_axis_tuser[0] !== expected_chars[0].fits)
                    report_mismatch("fits", 64'(expected_chars[0].fits),
                                    64'(m_axis_tuser[0]));
                if (m_axis_tlast !== expected_chars[0].last)
                    report_mismatch("last_char", 64'(expected_chars[0].last),
                                    64'(m_axis_tlast));
                if (m_axis_tdata[12:8] !== expected_chars[0].length)
                    report_mismatch("total_length", 64'(expected_chars[0].length),
                                    64'(m_axis_tdata[12:8]));
                void'(expected_chars.pop_front());
            end
            beats_out++;
        end
    end

    // Watchdog: the run is declared hung when neither stream moves a beat
    // for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HangLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_stim_row   directed_rows [23];
        int unsigned idle_plan [3][2];
        logic [63:0] raw;
        logic [1:0]  sel;
        logic        sgn;
        logic [7:0]  cap;

        // Hand-picked cases: the unsigned maximum and signed minimum of each width, zero,
        // bits above the selected width, and capacities that are zero, just
        // enough and one short. Rows marked ROW_PREDICT use the predictor.
        directed_rows = '{
            '{64'd0,                  SelW8,  1'b0, 8'd1,   ROW_TEXT,    "0"},
            '{64'hFF,                 SelW8,  1'b0, 8'd3,   ROW_TEXT,    "255"},
            '{64'h80,                 SelW8,  1'b1, 8'd3,   ROW_TEXT,    "-128"},
            '{64'hFF,                 SelW8,  1'b1, 8'd1,   ROW_TEXT,    "-1"},
            '{64'hFFFF,               SelW16, 1'b0, 8'd5,   ROW_TEXT,    "65535"},
            '{64'h8000,               SelW16, 1'b1, 8'd5,   ROW_TEXT,    "-32768"},
            '{64'hFFFF_FFFF,          SelW32, 1'b0, 8'd10,  ROW_TEXT,    "4294967295"},
            '{64'h8000_0000,          SelW32, 1'b1, 8'd10,  ROW_TEXT,    "-2147483648"},
            '{64'hFFFF_FFFF_FFFF_FFFF, SelW64, 1'b0, 8'd20, ROW_TEXT,    "18446744073709551615"},
            '{64'h8000_0000_0000_0000, SelW64, 1'b1, 8'd19, ROW_TEXT,    "-9223372036854775808"},
            '{64'h7FFF_FFFF_FFFF_FFFF, SelW64, 1'b1, 8'd255, ROW_TEXT,   "9223372036854775807"},
            // Upper bits must be ignored for narrow widths.
            '{64'hDEAD_BEEF_CAFE_FF05, SelW8,  1'b0, 8'd1,  ROW_TEXT,    "5"},
            '{64'hFFFF_FFFF_FFFF_0001, SelW16, 1'b1, 8'd1,  ROW_TEXT,    "1"},
            // A zero capacity refuses everything, zero included.
            '{64'd0,                  SelW8,  1'b0, 8'd0,   ROW_REFUSED, ""},
            '{64'hFFFF_FFFF_FFFF_FFFF, SelW64, 1'b1, 8'd0,  ROW_REFUSED, ""},
            '{64'd1000,               SelW16, 1'b0, 8'd3,   ROW_REFUSED, ""},
            '{64'd999,                SelW16, 1'b0, 8'd3,   ROW_TEXT,    "999"},
            // The sign does not count against the capacity.
            '{64'h9C,                 SelW8,  1'b1, 8'd2,   ROW_REFUSED, ""},
            '{64'h9D,                 SelW8,  1'b1, 8'd2,   ROW_TEXT,    "-99"},
            '{64'hFFFF_FFFF_FFFF_FFFF, SelW64, 1'b0, 8'd19, ROW_REFUSED, ""},
            '{64'd0,                  SelW64, 1'b1, 8'd255, ROW_TEXT,    "0"},
            '{64'h5555_5555_5555_5555, SelW64, 1'b0, 8'd20, ROW_PREDICT, ""},
            '{64'hAAAA_AAAA_AAAA_AAAA, SelW32, 1'b1, 8'd10, ROW_PREDICT, ""}
        };
        // Idle percentages per phase: {sender, receiver}.
        idle_plan = '{'{26, 61}, '{61, 26}, '{0, 0}};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = idle_plan[phase][0];
            recv_idle_pct = idle_plan[phase][1];

            if (phase == 0) begin
                foreach (directed_rows[r]) begin
                    offer_integer(directed_rows[r].raw, directed_rows[r].sel,
                                  directed_rows[r].sgn, directed_rows[r].cap);
                    // The first character comes out only after the conversion
                    // and the digit count, so queuing here is in time.
                    case (directed_rows[r].kind)
                        ROW_TEXT:    queue_text(directed_rows[r].text);
                        ROW_REFUSED: queue_refusal();
                        default: predict_decimal(directed_rows[r].raw, directed_rows[r].sel,
                                                 directed_rows[r].sgn, directed_rows[r].cap);
                    endcase
                end
            end

            repeat (RandomPerPhase) begin
                raw = {$urandom, $urandom};
                // Shifting and inverting spread the digit count over its
                // whole range, and small negatives show up too.
                if ($urandom_range(2) != 0) raw = raw >> $urandom_range(63);
                if ($urandom_range(3) == 0) raw = ~raw;
                sel = SelW'($urandom_range(3));
                sgn = 1'($urandom_range(1));
                case ($urandom_range(9))
                    0:       cap = 8'($urandom_range(255));
                    1:       cap = 8'd0;
                    default: cap = 8'($urandom_range(21, 1));
                endcase
                offer_integer(raw, sel, sgn, cap);
                predict_decimal(raw, sel, sgn, cap);
            end
        end
        s_axis_tvalid <= 1'b0;

        // The watchdog covers the case where the queue never empties.
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            report_mismatch("missing output beats", 64'd0, 64'(expected_chars.size()));
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
